/* rtl/fiducial_bearing_distance_estimator_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the fiducial bearing and distance estimator
// Shared immediate-consequence and next-cycle assertion forms.
// ----------------------------------------------------------------------------
`ifndef FIDUCIAL_BEARING_DISTANCE_ESTIMATOR_ASSERT_SVH
`define FIDUCIAL_BEARING_DISTANCE_ESTIMATOR_ASSERT_SVH

// Consequence must hold in the same cycle as the antecedent.
`define FBDE_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("fbde assertion failed");

// Consequence must hold in the cycle after the antecedent.
`define FBDE_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("fbde assertion failed");

`endif

/* rtl/fbde_pkg.sv */
// ----------------------------------------------------------------------------
// fbde_pkg
// Widths, register indexes, tag table and state type for the estimator.
// ----------------------------------------------------------------------------
package fbde_pkg;

    localparam int NUM_TAGS    = 12;
    localparam int NUM_TARGETS = 3;
    localparam int TGT_IDX_W   = (NUM_TARGETS > 1) ? $clog2(NUM_TARGETS) : 1;

    localparam int DRONE_W = 2;
    localparam int TAG_W   = 4;
    localparam int AREA_W  = 24;
    localparam int TRANS_W = 24;
    localparam int QUAT_W  = 16;
    localparam int OFS_W   = 18;
    localparam int DIST_W  = 24;
    localparam int BEAR_W  = 16;

    localparam int NUM_REGS  = 6;
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_TGT_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TGT_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TGT_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CAM_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CAM_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CAM_Z = 3'd5;

    localparam logic signed [OFS_W-1:0] RST_TGT_X = 18'sd0;
    localparam logic signed [OFS_W-1:0] RST_TGT_Y = -18'sd10486;
    localparam logic signed [OFS_W-1:0] RST_TGT_Z = -18'sd5571;
    localparam logic signed [OFS_W-1:0] RST_CAM_X = 18'sd4588;
    localparam logic signed [OFS_W-1:0] RST_CAM_Y = 18'sd0;
    localparam logic signed [OFS_W-1:0] RST_CAM_Z = 18'sd3604;

    // Shift-add multiplier: multiplier operand consumed one digit per cycle.
    localparam int MUL_A_W    = 32;
    localparam int MUL_B_W    = 28;
    localparam int MUL_DIG_W  = 4;
    localparam int MUL_DIGITS = MUL_B_W / MUL_DIG_W;
    localparam int MUL_CNT_W  = $clog2(MUL_DIGITS);
    localparam int MUL_P_W    = MUL_A_W + MUL_B_W;

    localparam int QP_W  = 30;
    localparam int ROT_W = 32;
    localparam int POS_W = 26;
    localparam int VEC_W = 27;
    localparam int MAG_W = 26;
    localparam int SQ_W  = 54;
    localparam int ROOT_W = SQ_W / 2;
    localparam int QUO_W  = 15;
    localparam int DIVD_W = MAG_W + QUO_W + 1;
    localparam int DIVS_W = ROOT_W + 1;
    localparam int FRAC_SH = 28;

    localparam logic [DIST_W-1:0] DIST_MAX = 24'd12582912;
    localparam logic [QUO_W-1:0]  BEAR_ONE = 15'd16384;

    // Quaternion product slots.
    localparam int QP_XY = 0;
    localparam int QP_ZW = 1;
    localparam int QP_XZ = 2;
    localparam int QP_YW = 3;
    localparam int QP_YZ = 4;
    localparam int QP_XW = 5;
    localparam int QP_XX = 6;
    localparam int QP_YY = 7;
    localparam int QP_ZZ = 8;
    localparam int NUM_QP = 9;

    localparam logic [DRONE_W-1:0] TAG_MAP [NUM_TAGS] = '{
        2'd1, 2'd1, 2'd1, 2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd3, 2'd3, 2'd3, 2'd3
    };

    // Target drone for a tag, zero when the tag has no table entry.
    function automatic logic [DRONE_W-1:0] tag_target(input logic [TAG_W-1:0] tag);
        logic [DRONE_W-1:0] tgt;
        tgt = '0;
        for (int k = 0; k < NUM_TAGS; k++) begin
            if (int'(tag) == k) begin
                tgt = TAG_MAP[k];
            end
        end
        return tgt;
    endfunction

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_QUAT,
        ST_ROT,
        ST_SQR,
        ST_ROOT,
        ST_DIV,
        ST_OUT
    } t_state;

endpackage

/* rtl/fbde_mul.sv */
// ----------------------------------------------------------------------------
// fbde_mul
// Signed shift-add multiplier, one digit of the second operand per cycle.
// ----------------------------------------------------------------------------
module fbde_mul (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic signed [fbde_pkg::MUL_A_W-1:0]  i_a,
    input  logic signed [fbde_pkg::MUL_B_W-1:0]  i_b,
    output logic                                 o_done,
    output logic signed [fbde_pkg::MUL_P_W-1:0]  o_prod
);

    logic signed [fbde_pkg::MUL_P_W-1:0]   r_a;
    logic        [fbde_pkg::MUL_B_W-1:0]   r_b;
    logic signed [fbde_pkg::MUL_P_W-1:0]   r_acc;
    logic        [fbde_pkg::MUL_CNT_W-1:0] r_cnt;
    logic                                  r_busy;
    logic                                  r_done;

    logic                                  last;
    logic signed [fbde_pkg::MUL_DIG_W:0]   digit;
    logic signed [fbde_pkg::MUL_P_W-1:0]   pp;

    // The top digit carries the sign of the two's complement operand.
    always_comb begin
        last  = (r_cnt == fbde_pkg::MUL_CNT_W'(fbde_pkg::MUL_DIGITS - 1));
        digit = {last & r_b[fbde_pkg::MUL_DIG_W-1], r_b[fbde_pkg::MUL_DIG_W-1:0]};
        pp    = r_a * digit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_a   <= fbde_pkg::MUL_P_W'(i_a);
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= r_acc + pp;
            r_a   <= r_a <<< fbde_pkg::MUL_DIG_W;
            r_b   <= r_b >> fbde_pkg::MUL_DIG_W;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

/* rtl/fbde_sqrt.sv */
// ----------------------------------------------------------------------------
// fbde_sqrt
// Integer square root, two radicand bits and one root bit per cycle.
// ----------------------------------------------------------------------------
module fbde_sqrt (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [fbde_pkg::SQ_W-1:0]         i_rad,
    output logic                              o_done,
    output logic [fbde_pkg::ROOT_W-1:0]       o_root
);

    localparam int REM_W = fbde_pkg::ROOT_W + 3;
    localparam int CNT_W = $clog2(fbde_pkg::ROOT_W);

    logic [fbde_pkg::SQ_W-1:0]   r_rad;
    logic [REM_W-1:0]            r_rem;
    logic [fbde_pkg::ROOT_W-1:0] r_root;
    logic [CNT_W-1:0]            r_cnt;
    logic                        r_busy;
    logic                        r_done;

    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic             ge;
    logic             last;

    always_comb begin
        rem_sh = {r_rem[REM_W-3:0], r_rad[fbde_pkg::SQ_W-1 -: 2]};
        trial  = {1'b0, r_root, 2'b01};
        ge     = (rem_sh >= trial);
        last   = (r_cnt == CNT_W'(fbde_pkg::ROOT_W - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_rad  <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= r_rad << 2;
            r_rem  <= ge ? (rem_sh - trial) : rem_sh;
            r_root <= {r_root[fbde_pkg::ROOT_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

/* rtl/fbde_div.sv */
// ----------------------------------------------------------------------------
// fbde_div
// Restoring divider, one quotient bit per cycle, for a quotient known to
// fit in QUO_W bits.
// ----------------------------------------------------------------------------
module fbde_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [fbde_pkg::DIVD_W-1:0]       i_dividend,
    input  logic [fbde_pkg::DIVS_W-1:0]       i_divisor,
    output logic                              o_done,
    output logic [fbde_pkg::QUO_W-1:0]        o_quot
);

    localparam int CNT_W = $clog2(fbde_pkg::QUO_W);

    logic [fbde_pkg::DIVS_W-1:0] r_rem;
    logic [fbde_pkg::DIVS_W-1:0] r_den;
    logic [fbde_pkg::QUO_W-1:0]  r_low;
    logic [fbde_pkg::QUO_W-1:0]  r_quot;
    logic [CNT_W-1:0]            r_cnt;
    logic                        r_busy;
    logic                        r_done;

    logic [fbde_pkg::DIVS_W:0]   rem_sh;
    logic [fbde_pkg::DIVS_W:0]   diff;
    logic                        ge;
    logic                        last;

    always_comb begin
        rem_sh = {r_rem, r_low[fbde_pkg::QUO_W-1]};
        diff   = rem_sh - {1'b0, r_den};
        ge     = (rem_sh >= {1'b0, r_den});
        last   = (r_cnt == CNT_W'(fbde_pkg::QUO_W - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // The upper dividend bits are already below the divisor, so only the
    // low QUO_W bits need a step each.
    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_rem  <= fbde_pkg::DIVS_W'(i_dividend[fbde_pkg::DIVD_W-1:fbde_pkg::QUO_W]);
            r_low  <= i_dividend[fbde_pkg::QUO_W-1:0];
            r_den  <= i_divisor;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= ge ? diff[fbde_pkg::DIVS_W-1:0] : rem_sh[fbde_pkg::DIVS_W-1:0];
            r_low  <= r_low << 1;
            r_quot <= {r_quot[fbde_pkg::QUO_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

/* rtl/fiducial_bearing_distance_estimator.sv */
// ----------------------------------------------------------------------------
// fiducial_bearing_distance_estimator
// Marker pose to body-frame distance and unit bearing toward a target drone.
// ----------------------------------------------------------------------------
//  channel  | valid        | ready         | payload
//  ---------+--------------+---------------+---------------------------------
//  config   | i_cfg_valid  | o_cfg_ready   | i_cfg_index, i_cfg_data
//  input    | i_in_valid   | o_in_ready    | i_first_of_message .. i_quat_z
//  output   | o_out_valid  | i_out_ready   | o_source_drone .. o_bearing_z
//
//  An item that yields a result runs 21 products on the shift-add multiplier,
//  one pass through the square root unit and three divisions, which are
//  skipped when the norm is zero. An item that yields no result leaves the block idle.
//  Input is taken only while idle; a finished result waits in the output
//  register while the next item is accepted. Reset is synchronous, low.
// ----------------------------------------------------------------------------
module fiducial_bearing_distance_estimator (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [fbde_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic signed [fbde_pkg::OFS_W-1:0]      i_cfg_data,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic                                   i_first_of_message,
    input  logic [fbde_pkg::DRONE_W-1:0]           i_observer_drone,
    input  logic [fbde_pkg::TAG_W-1:0]             i_tag_id,
    input  logic [fbde_pkg::AREA_W-1:0]            i_tag_area,
    input  logic signed [fbde_pkg::TRANS_W-1:0]    i_trans_x,
    input  logic signed [fbde_pkg::TRANS_W-1:0]    i_trans_y,
    input  logic signed [fbde_pkg::TRANS_W-1:0]    i_trans_z,
    input  logic signed [fbde_pkg::QUAT_W-1:0]     i_quat_w,
    input  logic signed [fbde_pkg::QUAT_W-1:0]     i_quat_x,
    input  logic signed [fbde_pkg::QUAT_W-1:0]     i_quat_y,
    input  logic signed [fbde_pkg::QUAT_W-1:0]     i_quat_z,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic [fbde_pkg::DRONE_W-1:0]           o_source_drone,
    output logic [fbde_pkg::DRONE_W-1:0]           o_target_drone,
    output logic [fbde_pkg::DIST_W-1:0]            o_distance,
    output logic signed [fbde_pkg::BEAR_W-1:0]     o_bearing_x,
    output logic signed [fbde_pkg::BEAR_W-1:0]     o_bearing_y,
    output logic signed [fbde_pkg::BEAR_W-1:0]     o_bearing_z
);

    fbde_pkg::t_state r_state, n_state;

    logic signed [fbde_pkg::OFS_W-1:0]   r_cfg [fbde_pkg::NUM_REGS];
    logic [fbde_pkg::NUM_TARGETS-1:0]    r_seen;
    logic [fbde_pkg::NUM_TARGETS-1:0]    n_seen;
    logic [fbde_pkg::AREA_W-1:0]         r_best [fbde_pkg::NUM_TARGETS];

    logic [fbde_pkg::DRONE_W-1:0]        r_obs;
    logic [fbde_pkg::DRONE_W-1:0]        r_tgt;
    logic signed [fbde_pkg::TRANS_W-1:0] r_trans [3];
    logic signed [fbde_pkg::QUAT_W-1:0]  r_qw, r_qx, r_qy, r_qz;

    logic signed [fbde_pkg::QP_W-1:0]    r_qp [fbde_pkg::NUM_QP];
    logic signed [fbde_pkg::MUL_P_W-1:0] r_racc;
    logic signed [fbde_pkg::POS_W-1:0]   r_p [3];
    logic [fbde_pkg::SQ_W-1:0]           r_sq;
    logic [fbde_pkg::ROOT_W-1:0]         r_norm;
    logic signed [fbde_pkg::BEAR_W-1:0]  r_bear [3];

    logic [3:0] r_job;
    logic [1:0] r_row;
    logic [1:0] r_col;
    logic       r_pending;

    logic                               r_out_valid;
    logic [fbde_pkg::DRONE_W-1:0]       r_o_src;
    logic [fbde_pkg::DRONE_W-1:0]       r_o_tgt;
    logic [fbde_pkg::DIST_W-1:0]        r_o_dist;
    logic signed [fbde_pkg::BEAR_W-1:0] r_o_bear [3];

    // Control outputs of the sequencer.
    logic in_ready, mul_start, sqrt_start, div_start, out_load;

    logic                               accept;
    logic [fbde_pkg::DRONE_W-1:0]       in_tgt;
    logic                               tgt_ok;
    logic [fbde_pkg::TGT_IDX_W-1:0]     ti;
    logic                               seen_eff;
    logic                               hit;

    logic signed [fbde_pkg::ROT_W-1:0]  rot [3][3];
    logic signed [fbde_pkg::VEC_W-1:0]  bv [3];
    logic signed [fbde_pkg::QUAT_W-1:0] qa, qb;
    logic signed [fbde_pkg::MUL_A_W-1:0] mul_a;
    logic signed [fbde_pkg::MUL_B_W-1:0] mul_b;
    logic                                mul_done;
    logic signed [fbde_pkg::MUL_P_W-1:0] mul_prod;
    logic signed [fbde_pkg::MUL_P_W-1:0] rot_sum;
    logic signed [fbde_pkg::MUL_P_W-1:0] rot_rnd;

    logic                               sqrt_done;
    logic [fbde_pkg::ROOT_W-1:0]        sqrt_root;

    logic signed [fbde_pkg::VEC_W-1:0]  cur_b;
    logic [fbde_pkg::VEC_W-1:0]         cur_abs;
    logic [fbde_pkg::DIVD_W-1:0]        dividend;
    logic [fbde_pkg::DIVS_W-1:0]        divisor;
    logic                               div_done;
    logic [fbde_pkg::QUO_W-1:0]         quot;
    logic [fbde_pkg::QUO_W-1:0]         quot_c;

    logic mul_last, div_last;

    // ------------------------------------------------------------------
    // Input decode and per-target best area
    // ------------------------------------------------------------------
    always_comb begin
        in_tgt   = fbde_pkg::tag_target(i_tag_id);
        tgt_ok   = (in_tgt != '0) && (int'(in_tgt) <= fbde_pkg::NUM_TARGETS);
        ti       = fbde_pkg::TGT_IDX_W'(in_tgt - 1'b1);
        seen_eff = !i_first_of_message && r_seen[ti];
        hit      = tgt_ok && (!seen_eff || (i_tag_area > r_best[ti]));
        accept   = i_in_valid && in_ready;
    end

    // A first-of-message item clears every seen flag before its own update.
    always_comb begin
        n_seen = i_first_of_message ? '0 : r_seen;
        if (hit) begin
            n_seen[ti] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
        end else if (accept) begin
            r_seen <= n_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && hit) begin
            r_best[ti] <= i_tag_area;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_obs      <= i_observer_drone;
            r_tgt      <= in_tgt;
            r_trans[0] <= i_trans_x;
            r_trans[1] <= i_trans_y;
            r_trans[2] <= i_trans_z;
            r_qw       <= i_quat_w;
            r_qx       <= i_quat_x;
            r_qy       <= i_quat_y;
            r_qz       <= i_quat_z;
        end
    end

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg[fbde_pkg::REG_TGT_X] <= fbde_pkg::RST_TGT_X;
            r_cfg[fbde_pkg::REG_TGT_Y] <= fbde_pkg::RST_TGT_Y;
            r_cfg[fbde_pkg::REG_TGT_Z] <= fbde_pkg::RST_TGT_Z;
            r_cfg[fbde_pkg::REG_CAM_X] <= fbde_pkg::RST_CAM_X;
            r_cfg[fbde_pkg::REG_CAM_Y] <= fbde_pkg::RST_CAM_Y;
            r_cfg[fbde_pkg::REG_CAM_Z] <= fbde_pkg::RST_CAM_Z;
        end else if (i_cfg_valid) begin
            for (int k = 0; k < fbde_pkg::NUM_REGS; k++) begin
                if (int'(i_cfg_index) == k) begin
                    r_cfg[k] <= i_cfg_data;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Rotation matrix in Q.28 from the stored quaternion products
    // ------------------------------------------------------------------
    function automatic logic signed [fbde_pkg::ROT_W-1:0] twice_sum(
        input logic signed [fbde_pkg::QP_W-1:0] a,
        input logic signed [fbde_pkg::QP_W-1:0] b,
        input logic                             sub
    );
        logic signed [fbde_pkg::ROT_W-1:0] s;
        s = sub ? (fbde_pkg::ROT_W'(a) - fbde_pkg::ROT_W'(b))
                : (fbde_pkg::ROT_W'(a) + fbde_pkg::ROT_W'(b));
        return s <<< 1;
    endfunction

    localparam logic signed [fbde_pkg::ROT_W-1:0] ONE_Q28 = 32'sd1 <<< fbde_pkg::FRAC_SH;

    always_comb begin
        rot[0][0] = ONE_Q28 - twice_sum(r_qp[fbde_pkg::QP_YY], r_qp[fbde_pkg::QP_ZZ], 1'b0);
        rot[0][1] = twice_sum(r_qp[fbde_pkg::QP_XY], r_qp[fbde_pkg::QP_ZW], 1'b1);
        rot[0][2] = twice_sum(r_qp[fbde_pkg::QP_XZ], r_qp[fbde_pkg::QP_YW], 1'b0);
        rot[1][0] = twice_sum(r_qp[fbde_pkg::QP_XY], r_qp[fbde_pkg::QP_ZW], 1'b0);
        rot[1][1] = ONE_Q28 - twice_sum(r_qp[fbde_pkg::QP_XX], r_qp[fbde_pkg::QP_ZZ], 1'b0);
        rot[1][2] = twice_sum(r_qp[fbde_pkg::QP_YZ], r_qp[fbde_pkg::QP_XW], 1'b1);
        rot[2][0] = twice_sum(r_qp[fbde_pkg::QP_XZ], r_qp[fbde_pkg::QP_YW], 1'b1);
        rot[2][1] = twice_sum(r_qp[fbde_pkg::QP_YZ], r_qp[fbde_pkg::QP_XW], 1'b0);
        rot[2][2] = ONE_Q28 - twice_sum(r_qp[fbde_pkg::QP_XX], r_qp[fbde_pkg::QP_YY], 1'b0);
    end

    // Camera to body axes: bx = pz, by = -px, bz = -py, then camera offset.
    always_comb begin
        bv[0] = fbde_pkg::VEC_W'(r_p[2]) + fbde_pkg::VEC_W'(r_cfg[fbde_pkg::REG_CAM_X]);
        bv[1] = fbde_pkg::VEC_W'(r_cfg[fbde_pkg::REG_CAM_Y]) - fbde_pkg::VEC_W'(r_p[0]);
        bv[2] = fbde_pkg::VEC_W'(r_cfg[fbde_pkg::REG_CAM_Z]) - fbde_pkg::VEC_W'(r_p[1]);
    end

    // ------------------------------------------------------------------
    // Multiplier operand selection
    // ------------------------------------------------------------------
    always_comb begin
        case (r_job)
            4'd0:    begin qa = r_qx; qb = r_qy; end
            4'd1:    begin qa = r_qz; qb = r_qw; end
            4'd2:    begin qa = r_qx; qb = r_qz; end
            4'd3:    begin qa = r_qy; qb = r_qw; end
            4'd4:    begin qa = r_qy; qb = r_qz; end
            4'd5:    begin qa = r_qx; qb = r_qw; end
            4'd6:    begin qa = r_qx; qb = r_qx; end
            4'd7:    begin qa = r_qy; qb = r_qy; end
            default: begin qa = r_qz; qb = r_qz; end
        endcase

        cur_b = bv[0];
        for (int k = 1; k < 3; k++) begin
            if (int'(r_job) == k) begin
                cur_b = bv[k];
            end
        end

        case (r_state)
            fbde_pkg::ST_QUAT: begin
                mul_a = fbde_pkg::MUL_A_W'(qa);
                mul_b = fbde_pkg::MUL_B_W'(qb);
            end
            fbde_pkg::ST_ROT: begin
                mul_a = fbde_pkg::MUL_A_W'(rot[r_row][r_col]);
                mul_b = fbde_pkg::MUL_B_W'(r_cfg[r_col]);
            end
            fbde_pkg::ST_SQR: begin
                mul_a = fbde_pkg::MUL_A_W'(cur_b);
                mul_b = fbde_pkg::MUL_B_W'(cur_b);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    fbde_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    // Row sum rounded to Q16.16: add half, then floor by taking upper bits.
    always_comb begin
        rot_sum = r_racc + mul_prod;
        rot_rnd = rot_sum + (fbde_pkg::MUL_P_W'(1) <<< (fbde_pkg::FRAC_SH - 1));
    end

    fbde_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sqrt_start),
        .i_rad   (r_sq),
        .o_done  (sqrt_done),
        .o_root  (sqrt_root)
    );

    // Bearing = round(|b| * 16384 / n) = floor((|b| * 32768 + n) / (2n)).
    always_comb begin
        cur_abs  = cur_b[fbde_pkg::VEC_W-1] ? fbde_pkg::VEC_W'(-cur_b)
                                            : fbde_pkg::VEC_W'(cur_b);
        dividend = fbde_pkg::DIVD_W'({cur_abs[fbde_pkg::MAG_W-1:0], fbde_pkg::QUO_W'(0)})
                 + fbde_pkg::DIVD_W'(r_norm);
        divisor  = {r_norm, 1'b0};
        quot_c   = (quot > fbde_pkg::BEAR_ONE) ? fbde_pkg::BEAR_ONE : quot;
    end

    fbde_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (dividend),
        .i_divisor  (divisor),
        .o_done     (div_done),
        .o_quot     (quot)
    );

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        mul_last = 1'b0;
        case (r_state)
            fbde_pkg::ST_QUAT: mul_last = (int'(r_job) == fbde_pkg::NUM_QP - 1);
            fbde_pkg::ST_ROT:  mul_last = (r_row == 2'd2) && (r_col == 2'd2);
            fbde_pkg::ST_SQR:  mul_last = (r_job == 4'd2);
            default:           mul_last = 1'b0;
        endcase
        div_last = (r_job == 4'd2);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            fbde_pkg::ST_IDLE: begin
                if (accept && hit) begin
                    n_state = fbde_pkg::ST_QUAT;
                end
            end
            fbde_pkg::ST_QUAT: begin
                if (mul_done && mul_last) begin
                    n_state = fbde_pkg::ST_ROT;
                end
            end
            fbde_pkg::ST_ROT: begin
                if (mul_done && mul_last) begin
                    n_state = fbde_pkg::ST_SQR;
                end
            end
            fbde_pkg::ST_SQR: begin
                if (mul_done && mul_last) begin
                    n_state = fbde_pkg::ST_ROOT;
                end
            end
            fbde_pkg::ST_ROOT: begin
                if (sqrt_done) begin
                    n_state = (sqrt_root == '0) ? fbde_pkg::ST_OUT : fbde_pkg::ST_DIV;
                end
            end
            fbde_pkg::ST_DIV: begin
                if (div_done && div_last) begin
                    n_state = fbde_pkg::ST_OUT;
                end
            end
            fbde_pkg::ST_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = fbde_pkg::ST_IDLE;
                end
            end
            default: n_state = fbde_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        in_ready   = 1'b0;
        mul_start  = 1'b0;
        sqrt_start = 1'b0;
        div_start  = 1'b0;
        out_load   = 1'b0;
        case (r_state)
            fbde_pkg::ST_IDLE: in_ready   = 1'b1;
            fbde_pkg::ST_QUAT: mul_start  = !r_pending;
            fbde_pkg::ST_ROT:  mul_start  = !r_pending;
            fbde_pkg::ST_SQR:  mul_start  = !r_pending;
            fbde_pkg::ST_ROOT: sqrt_start = !r_pending;
            fbde_pkg::ST_DIV:  div_start  = !r_pending;
            fbde_pkg::ST_OUT:  out_load   = !r_out_valid || i_out_ready;
            default:           in_ready   = 1'b0;
        endcase
    end

    assign o_in_ready = in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= fbde_pkg::ST_IDLE;
            r_pending <= 1'b0;
            r_job     <= '0;
            r_row     <= '0;
            r_col     <= '0;
        end else begin
            r_state <= n_state;
            if (mul_start || sqrt_start || div_start) begin
                r_pending <= 1'b1;
            end else if (mul_done || sqrt_done || div_done) begin
                r_pending <= 1'b0;
            end
            if (r_state != n_state) begin
                r_job <= '0;
                r_row <= '0;
                r_col <= '0;
            end else if (mul_done || div_done) begin
                r_job <= r_job + 1'b1;
                if (r_col == 2'd2) begin
                    r_col <= '0;
                    r_row <= r_row + 1'b1;
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end
        end
    end

    // Datapath registers filled as each unit finishes.
    always_ff @(posedge i_clk) begin
        if (r_state == fbde_pkg::ST_IDLE) begin
            r_racc <= '0;
            r_sq   <= '0;
        end
        if (mul_done) begin
            case (r_state)
                fbde_pkg::ST_QUAT: begin
                    for (int k = 0; k < fbde_pkg::NUM_QP; k++) begin
                        if (int'(r_job) == k) begin
                            r_qp[k] <= mul_prod[fbde_pkg::QP_W-1:0];
                        end
                    end
                end
                fbde_pkg::ST_ROT: begin
                    if (r_col == 2'd2) begin
                        r_racc <= '0;
                        for (int k = 0; k < 3; k++) begin
                            if (int'(r_row) == k) begin
                                r_p[k] <= $signed(rot_rnd[fbde_pkg::FRAC_SH +: fbde_pkg::POS_W])
                                        + fbde_pkg::POS_W'(r_trans[k]);
                            end
                        end
                    end else begin
                        r_racc <= rot_sum;
                    end
                end
                fbde_pkg::ST_SQR: begin
                    r_sq <= r_sq + mul_prod[fbde_pkg::SQ_W-1:0];
                end
                default: begin
                    r_racc <= r_racc;
                end
            endcase
        end
        if (sqrt_done) begin
            r_norm <= sqrt_root;
            for (int k = 0; k < 3; k++) begin
                r_bear[k] <= '0;
            end
        end
        if (div_done) begin
            for (int k = 0; k < 3; k++) begin
                if (int'(r_job) == k) begin
                    r_bear[k] <= cur_b[fbde_pkg::VEC_W-1]
                               ? -$signed(fbde_pkg::BEAR_W'(quot_c))
                               : $signed(fbde_pkg::BEAR_W'(quot_c));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_src  <= r_obs;
            r_o_tgt  <= r_tgt;
            r_o_dist <= (r_norm > fbde_pkg::ROOT_W'(fbde_pkg::DIST_MAX))
                      ? fbde_pkg::DIST_MAX : r_norm[fbde_pkg::DIST_W-1:0];
            for (int k = 0; k < 3; k++) begin
                r_o_bear[k] <= r_bear[k];
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_source_drone = r_o_src;
    assign o_target_drone = r_o_tgt;
    assign o_distance     = r_o_dist;
    assign o_bearing_x    = r_o_bear[0];
    assign o_bearing_y    = r_o_bear[1];
    assign o_bearing_z    = r_o_bear[2];

endmodule

/* rtl/fbde_checker.sv */
// ----------------------------------------------------------------------------
// fbde_checker
// Port-level checks on the result channel of the estimator.
// ----------------------------------------------------------------------------
`include "fiducial_bearing_distance_estimator_assert.svh"

module fbde_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                o_out_valid,
    input logic                                i_out_ready,
    input logic [fbde_pkg::DRONE_W-1:0]        o_target_drone,
    input logic [fbde_pkg::DIST_W-1:0]         o_distance,
    input logic signed [fbde_pkg::BEAR_W-1:0]  o_bearing_x,
    input logic signed [fbde_pkg::BEAR_W-1:0]  o_bearing_y
);

    // A stalled result stays offered, with its distance and x bearing unchanged.
    `FBDE_ASSERT_NXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid)
    `FBDE_ASSERT_NXT(a_out_stable, o_out_valid && !i_out_ready, $stable(o_distance) && $stable(o_bearing_x))

    // Results always name a real target and keep distance and x and y bearings to the saturated ranges.
    `FBDE_ASSERT_IMP(a_tgt_named, o_out_valid, o_target_drone != 2'd0)
    `FBDE_ASSERT_IMP(a_dist_sat, o_out_valid, o_distance <= 24'd12582912)
    `FBDE_ASSERT_IMP(a_bear_range, o_out_valid, (o_bearing_x <= 16'sd16384) && (o_bearing_x >= -16'sd16384) && (o_bearing_y <= 16'sd16384) && (o_bearing_y >= -16'sd16384))

endmodule

bind fiducial_bearing_distance_estimator fbde_checker u_fbde_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_target_drone (o_target_drone),
    .o_distance     (o_distance),
    .o_bearing_x    (o_bearing_x),
    .o_bearing_y    (o_bearing_y)
);

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fiducial bearing and distance estimator testbench
// Drives marker detections through the valid/ready input channel, predicts
// each fix in a local fixed-point model of the block and compares every
// output transfer field by field, across several offset register settings.
// ----------------------------------------------------------------------------
module testbench;
    import fbde_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int SETTLE      = 400;
    localparam int HOLD_LEN    = 3000;
    localparam longint DIST_SAT = 12582912;
    localparam longint Q28_ONE  = 64'sd1 <<< 28;

    typedef enum {CHK_NONE, CHK_FIXED, CHK_MODEL} t_chk;

    typedef struct {
        logic                       first;
        logic [DRONE_W-1:0]         obs;
        logic [TAG_W-1:0]           tag;
        logic [AREA_W-1:0]          area;
        logic signed [TRANS_W-1:0]  tx, ty, tz;
        logic signed [QUAT_W-1:0]   qw, qx, qy, qz;
    } t_marker;

    typedef struct {
        logic [DRONE_W-1:0]         src, tgt;
        logic [DIST_W-1:0]          range_q;
        logic signed [BEAR_W-1:0]   bx, by, bz;
    } t_fix;

    typedef struct {
        t_chk    chk;
        t_marker m;
        t_fix    f;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic signed [OFS_W-1:0] i_cfg_data = '0;
    logic i_in_valid = 1'b0;
    logic i_first_of_message = 1'b0;
    logic [DRONE_W-1:0] i_observer_drone = '0;
    logic [TAG_W-1:0] i_tag_id = '0;
    logic [AREA_W-1:0] i_tag_area = '0;
    logic signed [TRANS_W-1:0] i_trans_x = '0, i_trans_y = '0, i_trans_z = '0;
    logic signed [QUAT_W-1:0] i_quat_w = '0, i_quat_x = '0, i_quat_y = '0, i_quat_z = '0;
    logic i_out_ready = 1'b0;
    logic o_cfg_ready, o_in_ready, o_out_valid;
    logic [DRONE_W-1:0] o_source_drone, o_target_drone;
    logic [DIST_W-1:0] o_distance;
    logic signed [BEAR_W-1:0] o_bearing_x, o_bearing_y, o_bearing_z;

    fiducial_bearing_distance_estimator dut (.*);

    always #5 i_clk = ~i_clk;

    // Local copy of the offsets and of the per-target best areas.
    logic signed [OFS_W-1:0] offset_reg [NUM_REGS];
    logic [AREA_W-1:0] best_area [NUM_TARGETS];
    bit area_seen [NUM_TARGETS];

    t_fix pending_fixes [$];
    int errors = 0;
    int cycles = 0;
    int send_idle_pct = 14;
    int recv_idle_pct = 49;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic signed [BEAR_W-1:0] unit_comp(input longint c,
                                                           input longint unsigned n);
        longint unsigned mag, q;
        if (n == 0) return '0;
        mag = (c < 0) ? longint'(-c) : longint'(c);
        q = (mag * 32768 + n) / (2 * n);
        if (q > 16384) q = 16384;
        return (c < 0) ? -BEAR_W'(q) : BEAR_W'(q);
    endfunction

    // Updates the best areas and returns 1 with the fix when the marker yields one.
    function automatic bit estimate_fix(input t_marker m, output t_fix f);
        longint w, x, y, z, acc, n_sq;
        longint r [3][3];
        longint p [3];
        longint b [3];
        longint unsigned n;
        int ti;
        f = '{default: '0};
        if (m.first) area_seen = '{default: 0};
        if (int'(m.tag) >= NUM_TAGS) return 0;
        ti = int'(m.tag) / 4;
        if (ti >= NUM_TARGETS) return 0;
        if (area_seen[ti] && best_area[ti] >= m.area) return 0;
        best_area[ti] = m.area;
        area_seen[ti] = 1;
        w = m.qw; x = m.qx; y = m.qy; z = m.qz;
        r[0][0] = Q28_ONE - 2 * (y * y + z * z);
        r[0][1] = 2 * (x * y - z * w);
        r[0][2] = 2 * (x * z + y * w);
        r[1][0] = 2 * (x * y + z * w);
        r[1][1] = Q28_ONE - 2 * (x * x + z * z);
        r[1][2] = 2 * (y * z - x * w);
        r[2][0] = 2 * (x * z - y * w);
        r[2][1] = 2 * (y * z + x * w);
        r[2][2] = Q28_ONE - 2 * (x * x + y * y);
        for (int i = 0; i < 3; i++) begin
            acc = r[i][0] * longint'(offset_reg[REG_TGT_X])
                + r[i][1] * longint'(offset_reg[REG_TGT_Y])
                + r[i][2] * longint'(offset_reg[REG_TGT_Z]);
            p[i] = (acc + (64'sd1 <<< 27)) >>> 28;
        end
        p[0] += longint'(m.tx);
        p[1] += longint'(m.ty);
        p[2] += longint'(m.tz);
        // Camera axes to body axes, then the camera mounting offset.
        b[0] = p[2] + longint'(offset_reg[REG_CAM_X]);
        b[1] = -p[0] + longint'(offset_reg[REG_CAM_Y]);
        b[2] = -p[1] + longint'(offset_reg[REG_CAM_Z]);
        n_sq = b[0] * b[0] + b[1] * b[1] + b[2] * b[2];
        n = int_sqrt(longint'(n_sq));
        f.src = m.obs;
        f.tgt = DRONE_W'(ti + 1);
        f.range_q = (n > DIST_SAT) ? DIST_W'(DIST_SAT) : DIST_W'(n);
        f.bx = unit_comp(b[0], n);
        f.by = unit_comp(b[1], n);
        f.bz = unit_comp(b[2], n);
        return 1;
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Receiver: random stalls, plus a long hold-off whenever one is requested.
    always @(posedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_LEN;
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_fix e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_fixes.size() == 0) begin
                $error("unexpected output transfer");
                errors++;
            end else begin
                e = pending_fixes.pop_front();
                if (o_source_drone !== e.src) begin
                    $error("source_drone: expected %0d, got %0d", e.src, o_source_drone);
                    errors++;
                end
                if (o_target_drone !== e.tgt) begin
                    $error("target_drone: expected %0d, got %0d", e.tgt, o_target_drone);
                    errors++;
                end
                if (o_distance !== e.range_q) begin
                    $error("distance: expected %0d, got %0d", e.range_q, o_distance);
                    errors++;
                end
                if (o_bearing_x !== e.bx) begin
                    $error("bearing_x: expected %0d, got %0d", e.bx, o_bearing_x);
                    errors++;
                end
                if (o_bearing_y !== e.by) begin
                    $error("bearing_y: expected %0d, got %0d", e.by, o_bearing_y);
                    errors++;
                end
                if (o_bearing_z !== e.bz) begin
                    $error("bearing_z: expected %0d, got %0d", e.bz, o_bearing_z);
                    errors++;
                end
            end
        end
    end

    task automatic write_offset(input logic [CFG_IDX_W-1:0] idx,
                                input logic signed [OFS_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        offset_reg[idx] = val;
    endtask

    task automatic write_all(input logic signed [OFS_W-1:0] tx, ty, tz, cx, cy, cz);
        write_offset(REG_TGT_X, tx);
        write_offset(REG_TGT_Y, ty);
        write_offset(REG_TGT_Z, tz);
        write_offset(REG_CAM_X, cx);
        write_offset(REG_CAM_Y, cy);
        write_offset(REG_CAM_Z, cz);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_marker(input t_marker m, input t_chk chk, input t_fix fixed);
        t_fix pf;
        bit hit;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_first_of_message <= m.first;
        i_observer_drone <= m.obs;
        i_tag_id <= m.tag;
        i_tag_area <= m.area;
        i_trans_x <= m.tx;
        i_trans_y <= m.ty;
        i_trans_z <= m.tz;
        i_quat_w <= m.qw;
        i_quat_x <= m.qx;
        i_quat_y <= m.qy;
        i_quat_z <= m.qz;
        do @(posedge i_clk); while (!o_in_ready);
        hit = estimate_fix(m, pf);
        if (chk == CHK_FIXED) pending_fixes = {pending_fixes, fixed};
        else if (chk == CHK_MODEL && hit) pending_fixes = {pending_fixes, pf};
    endtask

    // Lowers valid, waits for every expected fix, then lets the block settle.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_fixes.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic logic signed [TRANS_W-1:0] rand_trans();
        case ($urandom_range(5))
            0: return TRANS_W'(6553600);
            1: return -TRANS_W'(6553600);
            2: return TRANS_W'(int'($urandom_range(131072)) - 65536);
            default: return TRANS_W'(int'($urandom_range(13107200)) - 6553600);
        endcase
    endfunction

    function automatic logic signed [QUAT_W-1:0] rand_quat();
        case ($urandom_range(5))
            0: return QUAT_W'(16384);
            1: return -QUAT_W'(16384);
            2: return '0;
            default: return QUAT_W'(int'($urandom_range(32768)) - 16384);
        endcase
    endfunction

    task automatic run_messages(input int count);
        t_marker m;
        t_fix none;
        int sent, len;
        none = '{default: '0};
        sent = 0;
        while (sent < count) begin
            len = $urandom_range(1, 6);
            for (int k = 0; k < len; k++) begin
                m.first = (k == 0);
                m.obs = DRONE_W'($urandom_range(1, 3));
                m.tag = TAG_W'($urandom_range(NUM_TAGS - 1));
                case ($urandom_range(3))
                    0: m.area = AREA_W'($urandom_range(15));
                    1: m.area = 24'hFFFFFF - AREA_W'($urandom_range(3));
                    default: m.area = AREA_W'($urandom);
                endcase
                m.tx = rand_trans();
                m.ty = rand_trans();
                m.tz = rand_trans();
                m.qw = rand_quat();
                m.qx = rand_quat();
                m.qy = rand_quat();
                m.qz = rand_quat();
                // Unknown tags mixed in as noise; they only ever clear.
                if ($urandom_range(9) == 0) begin
                    m.tag = TAG_W'($urandom_range(NUM_TAGS, 15));
                    m.first = $urandom_range(1);
                    send_marker(m, CHK_MODEL, none);
                end else begin
                    send_marker(m, CHK_MODEL, none);
                    sent++;
                end
            end
        end
    endtask

    localparam logic signed [QUAT_W-1:0] Q1 = 16'sd16384;
    localparam logic signed [QUAT_W-1:0] QM = -16'sd16384;
    localparam logic signed [TRANS_W-1:0] TP = 24'sd6553600;
    localparam logic signed [TRANS_W-1:0] TM = -24'sd6553600;
    localparam logic signed [TRANS_W-1:0] T1 = 24'sd65536;

    // Offsets are all zero for this table, so the simple rows can be read off by eye.
    t_row dir_rows [] = '{
        '{CHK_FIXED, '{1, 1, 0, 100, 0, 0, 0, Q1, 0, 0, 0}, '{1, 1, 0, 0, 0, 0}},
        '{CHK_NONE,  '{0, 2, 1, 100, 0, 0, T1, Q1, 0, 0, 0}, '{0, 0, 0, 0, 0, 0}},
        '{CHK_FIXED, '{0, 2, 2, 101, 0, 0, T1, Q1, 0, 0, 0}, '{2, 1, 65536, 16384, 0, 0}},
        '{CHK_NONE,  '{0, 1, 12, 500, T1, T1, T1, Q1, 0, 0, 0}, '{0, 0, 0, 0, 0, 0}},
        '{CHK_NONE,  '{1, 3, 15, 24'hFFFFFF, TM, TP, TM, QM, QM, QM, QM},
                     '{0, 0, 0, 0, 0, 0}},
        '{CHK_FIXED, '{0, 1, 3, 0, -T1, 0, 0, Q1, 0, 0, 0}, '{1, 1, 65536, 0, 16384, 0}},
        '{CHK_MODEL, '{0, 3, 4, 24'hFFFFFF, TP, TM, TP, QM, QM, QM, QM},
                     '{0, 0, 0, 0, 0, 0}},
        '{CHK_MODEL, '{0, 2, 8, 1, TM, TM, TM, 0, Q1, 0, 0}, '{0, 0, 0, 0, 0, 0}},
        '{CHK_FIXED, '{0, 3, 11, 5, 0, T1, 0, Q1, 0, 0, 0}, '{3, 3, 65536, 0, 0, -16384}},
        '{CHK_NONE,  '{0, 1, 7, 24'hFFFFFF, T1, 0, 0, Q1, 0, 0, 0}, '{0, 0, 0, 0, 0, 0}},
        '{CHK_NONE,  '{0, 1, 9, 0, T1, 0, 0, Q1, 0, 0, 0}, '{0, 0, 0, 0, 0, 0}},
        '{CHK_MODEL, '{1, 2, 5, 7, TP, TP, TP, 0, 0, Q1, 0}, '{0, 0, 0, 0, 0, 0}},
        '{CHK_MODEL, '{0, 1, 10, 9, 24'sd123456, -24'sd98765, 24'sd4321,
                      16'sd11585, 0, 0, 16'sd11585}, '{0, 0, 0, 0, 0, 0}},
        '{CHK_MODEL, '{0, 3, 6, 8, -24'sd777, 24'sd31, 24'sd90000,
                      16'sd8192, -16'sd8192, 16'sd8192, -16'sd8192}, '{0, 0, 0, 0, 0, 0}}
    };

    initial begin
        offset_reg[REG_TGT_X] = RST_TGT_X;
        offset_reg[REG_TGT_Y] = RST_TGT_Y;
        offset_reg[REG_TGT_Z] = RST_TGT_Z;
        offset_reg[REG_CAM_X] = RST_CAM_X;
        offset_reg[REG_CAM_Y] = RST_CAM_Y;
        offset_reg[REG_CAM_Z] = RST_CAM_Z;
        area_seen = '{default: 0};
        best_area = '{default: '0};
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset offsets first, then zero offsets for the directed table.
        run_messages(60);
        drain();
        write_all(0, 0, 0, 0, 0, 0);
        foreach (dir_rows[i]) send_marker(dir_rows[i].m, dir_rows[i].chk, dir_rows[i].f);
        drain();

        // Largest offsets; the output is held off so the block backs up.
        write_all(131071, 131071, 131071, 131071, 131071, 131071);
        hold_req++;
        run_messages(140);
        drain();

        send_idle_pct = 49;
        recv_idle_pct = 14;
        write_all(-131072, -131072, -131072, -131072, -131072, -131072);
        run_messages(70);
        // The sender pauses here until every fix has come back.
        drain();
        run_messages(70);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_all(OFS_W'($urandom), OFS_W'($urandom), OFS_W'($urandom),
                  OFS_W'($urandom), OFS_W'($urandom), OFS_W'($urandom));
        run_messages(140);
        drain();
        write_all(RST_TGT_X, RST_TGT_Y, RST_TGT_Z, RST_CAM_X, RST_CAM_Y, RST_CAM_Z);
        run_messages(200);
        drain();

        if (errors == 0 && pending_fixes.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
